### design/lspf_pkg.sv
// Package for the least-squares fit block: widths, queue entry type,
// and the product-term table the solver walks. No dependencies.
`timescale 1ns / 1ps
package lspf_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned WIDE_W     = 192;
  localparam int unsigned OPND_W     = 64;
  localparam int unsigned NUM_TERMS  = 30;
  localparam int unsigned TERM_W     = 5;

  // first and last term of each fit in the table below
  localparam logic [TERM_W-1:0] QUAD_FIRST = 5'd0;
  localparam logic [TERM_W-1:0] QUAD_LAST  = 5'd23;
  localparam logic [TERM_W-1:0] LIN_FIRST  = 5'd24;
  localparam logic [TERM_W-1:0] LIN_LAST   = 5'd29;

  typedef enum logic [3:0] {
    OP_S0, OP_S1, OP_S2, OP_S3, OP_S4, OP_T0, OP_T1, OP_T2, OP_ONE
  } op_sel_e;

  typedef enum logic [1:0] {
    TG_DET, TG_NA, TG_NB, TG_NC
  } target_e;

  typedef struct packed {
    op_sel_e a;
    op_sel_e b;
    op_sel_e c;
    target_e tgt;
    logic    neg;
  } term_t;

  // one finished data set, as handed from the accumulator to the solver
  typedef struct packed {
    logic              quad;
    logic [CNT_W-1:0]  s0;
    logic [31:0]       s1;
    logic [39:0]       s2;
    logic [47:0]       s3;
    logic [55:0]       s4;
    logic [63:0]       t0;
    logic [63:0]       t1;
    logic [63:0]       t2;
  } sums_t;

  function automatic term_t term_at(input logic [TERM_W-1:0] idx);
    term_t t;
    case (idx)
      5'd0:  t = '{OP_S4, OP_S2, OP_S0, TG_DET, 1'b0};
      5'd1:  t = '{OP_S4, OP_S1, OP_S1, TG_DET, 1'b1};
      5'd2:  t = '{OP_S3, OP_S3, OP_S0, TG_DET, 1'b1};
      5'd3:  t = '{OP_S3, OP_S1, OP_S2, TG_DET, 1'b0};
      5'd4:  t = '{OP_S2, OP_S3, OP_S1, TG_DET, 1'b0};
      5'd5:  t = '{OP_S2, OP_S2, OP_S2, TG_DET, 1'b1};
      5'd6:  t = '{OP_T2, OP_S2, OP_S0, TG_NA,  1'b0};
      5'd7:  t = '{OP_T2, OP_S1, OP_S1, TG_NA,  1'b1};
      5'd8:  t = '{OP_S3, OP_T1, OP_S0, TG_NA,  1'b1};
      5'd9:  t = '{OP_S3, OP_S1, OP_T0, TG_NA,  1'b0};
      5'd10: t = '{OP_S1, OP_T1, OP_S2, TG_NA,  1'b0};
      5'd11: t = '{OP_T0, OP_S2, OP_S2, TG_NA,  1'b1};
      5'd12: t = '{OP_S4, OP_T1, OP_S0, TG_NB,  1'b0};
      5'd13: t = '{OP_S4, OP_S1, OP_T0, TG_NB,  1'b1};
      5'd14: t = '{OP_T2, OP_S0, OP_S3, TG_NB,  1'b1};
      5'd15: t = '{OP_T2, OP_S1, OP_S2, TG_NB,  1'b0};
      5'd16: t = '{OP_S2, OP_S3, OP_T0, TG_NB,  1'b0};
      5'd17: t = '{OP_S2, OP_T1, OP_S2, TG_NB,  1'b1};
      5'd18: t = '{OP_S4, OP_S2, OP_T0, TG_NC,  1'b0};
      5'd19: t = '{OP_S4, OP_T1, OP_S1, TG_NC,  1'b1};
      5'd20: t = '{OP_S3, OP_T0, OP_S3, TG_NC,  1'b1};
      5'd21: t = '{OP_S3, OP_T1, OP_S2, TG_NC,  1'b0};
      5'd22: t = '{OP_T2, OP_S3, OP_S1, TG_NC,  1'b0};
      5'd23: t = '{OP_T2, OP_S2, OP_S2, TG_NC,  1'b1};
      5'd24: t = '{OP_S2, OP_S0, OP_ONE, TG_DET, 1'b0};
      5'd25: t = '{OP_S1, OP_S1, OP_ONE, TG_DET, 1'b1};
      5'd26: t = '{OP_T1, OP_S0, OP_ONE, TG_NB,  1'b0};
      5'd27: t = '{OP_S1, OP_T0, OP_ONE, TG_NB,  1'b1};
      5'd28: t = '{OP_S2, OP_T0, OP_ONE, TG_NC,  1'b0};
      5'd29: t = '{OP_S1, OP_T1, OP_ONE, TG_NC,  1'b1};
      default: t = '{OP_ONE, OP_ONE, OP_ONE, TG_DET, 1'b0};
    endcase
    return t;
  endfunction

  // operand as a 64-bit two's complement value; position sums are positive
  function automatic logic [OPND_W-1:0] op_val(input op_sel_e sel, input sums_t e);
    logic [OPND_W-1:0] v;
    unique case (sel)
      OP_S0:   v = 64'(e.s0);
      OP_S1:   v = 64'(e.s1);
      OP_S2:   v = 64'(e.s2);
      OP_S3:   v = 64'(e.s3);
      OP_S4:   v = 64'(e.s4);
      OP_T0:   v = e.t0;
      OP_T1:   v = e.t1;
      OP_T2:   v = e.t2;
      default: v = 64'd1;
    endcase
    return v;
  endfunction

endpackage

### design/lspf_intf.sv
// Channel interfaces of the fit block: sample in, result out, config write.
// Depends on nothing but the package-free field widths.
`timescale 1ns / 1ps
interface lspf_smp_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample;
  logic        last_sample;
  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface lspf_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] coef_square;
  logic [63:0] coef_linear;
  logic [63:0] coef_constant;
  logic        singular;
  logic [10:0] points_used;
  modport source (output valid, output coef_square, output coef_linear,
                  output coef_constant, output singular, output points_used,
                  input ready);
  modport sink   (input valid, input coef_square, input coef_linear,
                  input coef_constant, input singular, input points_used,
                  output ready);
endinterface

interface lspf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] fit_degree;
  modport source (output valid, output fit_degree, input ready);
  modport sink   (input valid, input fit_degree, output ready);
endinterface

### design/lspf_front.sv
// Front end: accumulates the power and value sums, one item per cycle while the
// set queue has room, and pushes a snapshot on the last item. Uses lspf_pkg.
`timescale 1ns / 1ps
module lspf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              smp_valid_i,
  output logic              smp_ready_o,
  input  logic [31:0]       sample_i,
  input  logic              last_i,
  input  logic              quad_i,
  input  logic              q_full_i,
  output logic              push_o,
  output lspf_pkg::sums_t   push_data_o
);

  logic [lspf_pkg::CNT_W-1:0] cnt_q, cnt_d;
  // powers of the next position x
  logic [10:0] p1_q, p1_d;
  logic [20:0] p2_q, p2_d;
  logic [30:0] p3_q, p3_d;
  logic [40:0] p4_q, p4_d;
  logic [31:0] s1_q, s1_d;
  logic [39:0] s2_q, s2_d;
  logic [47:0] s3_q, s3_d;
  logic [55:0] s4_q, s4_d;
  logic [63:0] t0_q, t0_d, t1_q, t1_d, t2_q, t2_d;
  logic        acc_en, take;
  logic signed [43:0] xy;
  logic signed [53:0] x2y;

  assign smp_ready_o = !q_full_i;
  assign take        = smp_valid_i && smp_ready_o;
  assign acc_en      = take && (32'(cnt_q) < lspf_pkg::MAX_POINTS);

  assign xy  = $signed({1'b0, p1_q}) * $signed(sample_i);
  assign x2y = $signed({1'b0, p2_q}) * $signed(sample_i);

  always_comb begin
    cnt_d = cnt_q;
    p1_d = p1_q; p2_d = p2_q; p3_d = p3_q; p4_d = p4_q;
    s1_d = s1_q; s2_d = s2_q; s3_d = s3_q; s4_d = s4_q;
    t0_d = t0_q; t1_d = t1_q; t2_d = t2_q;
    if (acc_en) begin
      cnt_d = cnt_q + 11'd1;
      s1_d  = s1_q + 32'(p1_q);
      s2_d  = s2_q + 40'(p2_q);
      s3_d  = s3_q + 48'(p3_q);
      s4_d  = s4_q + 56'(p4_q);
      t0_d  = t0_q + {{32{sample_i[31]}}, sample_i};
      t1_d  = t1_q + {{20{xy[43]}}, xy};
      t2_d  = t2_q + {{10{x2y[53]}}, x2y};
      // finite differences step (x+1)^k from x^k
      p1_d  = p1_q + 11'd1;
      p2_d  = p2_q + {9'd0, p1_q, 1'b0} + 21'd1;
      p3_d  = p3_q + 31'(p2_q) + {9'd0, p2_q, 1'b0} + 31'(p1_q) + {19'd0, p1_q, 1'b0}
              + 31'd1;
      p4_d  = p4_q + {8'd0, p3_q, 2'b00} + {19'd0, p2_q, 1'b0} + {18'd0, p2_q, 2'b00}
              + {28'd0, p1_q, 2'b00} + 41'd1;
    end
  end

  assign push_o = take && last_i;
  assign push_data_o = '{quad: quad_i, s0: cnt_d, s1: s1_d, s2: s2_d, s3: s3_d,
                         s4: s4_d, t0: t0_d, t1: t1_d, t2: t2_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      p1_q <= 11'd1; p2_q <= 21'd1; p3_q <= 31'd1; p4_q <= 41'd1;
      s1_q <= '0; s2_q <= '0; s3_q <= '0; s4_q <= '0;
      t0_q <= '0; t1_q <= '0; t2_q <= '0;
    end else if (push_o) begin
      cnt_q <= '0;
      p1_q <= 11'd1; p2_q <= 21'd1; p3_q <= 31'd1; p4_q <= 41'd1;
      s1_q <= '0; s2_q <= '0; s3_q <= '0; s4_q <= '0;
      t0_q <= '0; t1_q <= '0; t2_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      p1_q <= p1_d; p2_q <= p2_d; p3_q <= p3_d; p4_q <= p4_d;
      s1_q <= s1_d; s2_q <= s2_d; s3_q <= s3_d; s4_q <= s4_d;
      t0_q <= t0_d; t1_q <= t1_d; t2_q <= t2_d;
    end
  end

endmodule

### design/lspf_queue.sv
// Two-entry queue of finished data sets between accumulator and solver.
// Uses lspf_pkg.
`timescale 1ns / 1ps
module lspf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lspf_pkg::sums_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output lspf_pkg::sums_t pop_data_o
);

  lspf_pkg::sums_t ent_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      fill_q;

  assign full_o     = fill_q == 2'd2;
  assign empty_o    = fill_q == 2'd0;
  assign pop_data_o = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### design/lspf_back.sv
// Back end: Cramer's-rule solver. A shift-add multiplier builds each
// product term, a restoring divider forms the Q32.32 quotients. Uses lspf_pkg.
`timescale 1ns / 1ps
module lspf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  lspf_pkg::sums_t q_data_i,
  output logic            pop_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [63:0]     coef_square_o,
  output logic [63:0]     coef_linear_o,
  output logic [63:0]     coef_constant_o,
  output logic            singular_o,
  output logic [10:0]     points_used_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_MUL1  = 4'd2;
  localparam logic [3:0] ST_MUL2  = 4'd3;
  localparam logic [3:0] ST_ACC   = 4'd4;
  localparam logic [3:0] ST_DIVLD = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_DIVFN = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  localparam int unsigned W = lspf_pkg::WIDE_W;

  logic [3:0]               st_q;
  lspf_pkg::sums_t          ent_q;
  logic [lspf_pkg::TERM_W-1:0] term_q;
  lspf_pkg::term_t          trm;
  logic [7:0]               cnt_q;
  logic [W-1:0]             acc_q, mcand_q, acc_d;
  logic [63:0]              mplier_q;
  logic [63:0]              opa;
  logic [W-1:0]             det_q, na_q, nb_q, nc_q;
  logic [W-1:0]             num, num_sh, rem_sh, n_q, rem_q, dvs_q, det_abs;
  logic [W:0]               diff;
  logic [63:0]              quo_q, mag, limit, coef;
  logic                     ovf_q, neg_q, ge, sat;
  logic [1:0]               k_q;
  logic [63:0]              ca_q, cb_q, cc_q;
  logic                     sing_q;

  assign trm = lspf_pkg::term_at(term_q);
  assign opa = lspf_pkg::op_val(trm.a, ent_q);

  // one multiplier bit per cycle; the top bit carries negative weight
  always_comb begin
    acc_d = acc_q;
    if (mplier_q[0]) begin
      acc_d = (cnt_q == 8'd63) ? acc_q - mcand_q : acc_q + mcand_q;
    end
  end

  always_comb begin
    case (k_q)
      2'd0:    num = na_q;
      2'd1:    num = nb_q;
      default: num = nc_q;
    endcase
  end
  assign num_sh  = {num[W-17:0], 16'd0};
  assign det_abs = det_q[W-1] ? -det_q : det_q;

  assign rem_sh = {rem_q[W-2:0], n_q[W-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, dvs_q};
  assign ge     = !diff[W];

  assign mag   = quo_q;
  assign limit = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  assign sat   = ovf_q || (mag > limit);
  assign coef  = sat ? limit : (neg_q ? -mag : mag);

  assign pop_o = (st_q == ST_IDLE) && !q_empty_i;

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        ent_q <= q_data_i;
        det_q <= '0; na_q <= '0; nb_q <= '0; nc_q <= '0;
      end
      ST_LOAD: begin
        mcand_q  <= {{(W-64){opa[63]}}, opa};
        mplier_q <= lspf_pkg::op_val(trm.b, ent_q);
        acc_q    <= '0;
      end
      ST_MUL1: begin
        if (cnt_q == 8'd63) begin
          mcand_q  <= acc_d;
          mplier_q <= lspf_pkg::op_val(trm.c, ent_q);
          acc_q    <= '0;
        end else begin
          acc_q    <= acc_d;
          mcand_q  <= {mcand_q[W-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[63:1]};
        end
      end
      ST_MUL2: begin
        acc_q    <= acc_d;
        mcand_q  <= {mcand_q[W-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[63:1]};
      end
      ST_ACC: begin
        unique case (trm.tgt)
          lspf_pkg::TG_DET: det_q <= trm.neg ? det_q - acc_q : det_q + acc_q;
          lspf_pkg::TG_NA:  na_q  <= trm.neg ? na_q - acc_q : na_q + acc_q;
          lspf_pkg::TG_NB:  nb_q  <= trm.neg ? nb_q - acc_q : nb_q + acc_q;
          default:          nc_q  <= trm.neg ? nc_q - acc_q : nc_q + acc_q;
        endcase
      end
      ST_DIVLD: begin
        n_q   <= num_sh[W-1] ? -num_sh : num_sh;
        dvs_q <= det_abs;
        rem_q <= '0;
        quo_q <= '0;
        ovf_q <= 1'b0;
        neg_q <= num[W-1] ^ det_q[W-1];
      end
      ST_DIV: begin
        rem_q <= ge ? diff[W-1:0] : rem_sh;
        n_q   <= {n_q[W-2:0], 1'b0};
        quo_q <= {quo_q[62:0], ge};
        ovf_q <= ovf_q | quo_q[63];
      end
      ST_DIVFN: begin
        case (k_q)
          2'd0:    ca_q <= coef;
          2'd1:    cb_q <= coef;
          default: cc_q <= coef;
        endcase
      end
      default: begin
      end
    endcase
    if (st_q == ST_DIVLD && det_q == '0) begin
      ca_q <= '0; cb_q <= '0; cc_q <= '0;
    end
    if (st_q == ST_OUT && (!res_valid_o || res_ready_i)) begin
      coef_square_o   <= ca_q;
      coef_linear_o   <= cb_q;
      coef_constant_o <= cc_q;
      singular_o      <= sing_q;
      points_used_o   <= ent_q.s0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      term_q      <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      sing_q      <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      if (st_q == ST_OUT && (!res_valid_o || res_ready_i)) begin
        res_valid_o <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_o <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            term_q <= q_data_i.quad ? lspf_pkg::QUAD_FIRST : lspf_pkg::LIN_FIRST;
            st_q   <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt_q <= '0;
          st_q  <= ST_MUL1;
        end
        ST_MUL1: begin
          cnt_q <= (cnt_q == 8'd63) ? 8'd0 : cnt_q + 8'd1;
          if (cnt_q == 8'd63) st_q <= ST_MUL2;
        end
        ST_MUL2: begin
          cnt_q <= cnt_q + 8'd1;
          if (cnt_q == 8'd63) st_q <= ST_ACC;
        end
        ST_ACC: begin
          if (term_q == (ent_q.quad ? lspf_pkg::QUAD_LAST : lspf_pkg::LIN_LAST)) begin
            k_q  <= 2'd0;
            st_q <= ST_DIVLD;
          end else begin
            term_q <= term_q + 5'd1;
            st_q   <= ST_LOAD;
          end
        end
        ST_DIVLD: begin
          cnt_q <= '0;
          if (det_q == '0) begin
            sing_q <= 1'b1;
            st_q   <= ST_OUT;
          end else begin
            sing_q <= 1'b0;
            st_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 8'd1;
          if (cnt_q == 8'(W - 1)) st_q <= ST_DIVFN;
        end
        ST_DIVFN: begin
          if (k_q == 2'd2) begin
            st_q <= ST_OUT;
          end else begin
            k_q  <= k_q + 2'd1;
            st_q <= ST_DIVLD;
          end
        end
        ST_OUT: begin
          if (!res_valid_o || res_ready_i) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/least_squares_poly_fit.sv
// Least-squares line / quadratic fit over a stream of Q16.16 samples at x = 1, 2, ...
// Samples are taken one per cycle while the two-entry queue of finished data
// sets has room; the item marked last closes a set and hands it to the solver.
// The solver forms each product term with a bit-serial 64-step multiplier
// (24 terms quadratic, 6 linear) and each of the three coefficients with a
// 192-step restoring divider. With both queue entries waiting, the sample
// input stalls until one drains.
// Top level; uses lspf_pkg, lspf_intf, lspf_front, lspf_queue, lspf_back.
`timescale 1ns / 1ps
module least_squares_poly_fit (
  input  logic             clk_i,
  input  logic             rst_ni,
  lspf_cfg_if.sink         cfg,
  lspf_smp_if.sink         smp,
  lspf_res_if.source       res
);

  logic [1:0]       degree_q;
  logic             q_full, q_empty, push, pop;
  lspf_pkg::sums_t  push_data, pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= 2'd1;
    end else if (cfg.valid) begin
      degree_q <= cfg.fit_degree;
    end
  end

  lspf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_valid_i (smp.valid),
    .smp_ready_o (smp.ready),
    .sample_i    (smp.sample),
    .last_i      (smp.last_sample),
    .quad_i      (degree_q[1]),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  lspf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  lspf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (pop_data),
    .pop_o           (pop),
    .res_valid_o     (res.valid),
    .res_ready_i     (res.ready),
    .coef_square_o   (res.coef_square),
    .coef_linear_o   (res.coef_linear),
    .coef_constant_o (res.coef_constant),
    .singular_o      (res.singular),
    .points_used_o   (res.points_used)
  );

endmodule

### design/lspf_chk.sv
// Port-level checker for the fit block, bound to the top level.
// Depends on lspf_intf.
`timescale 1ns / 1ps
module lspf_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  lspf_cfg_if.sink    cfg,
  lspf_res_if.source  res
);

  logic [1:0] deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= 2'd1;
    end else if (cfg.valid && cfg.ready) begin
      deg_q <= cfg.fit_degree;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res.ready |=> res.valid && $stable(res.coef_linear)
      && $stable(res.coef_constant) && $stable(res.points_used))
    else $error("result changed while stalled");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.singular |-> res.coef_square == 64'd0
      && res.coef_linear == 64'd0 && res.coef_constant == 64'd0)
    else $error("singular fit with nonzero coefficients");

  a_line_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !deg_q[1] |-> res.coef_square == 64'd0)
    else $error("square term in straight-line fit");

  a_few_pts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.points_used < 11'd2 |-> res.singular)
    else $error("fewer than two points not flagged singular");

endmodule

bind least_squares_poly_fit lspf_chk u_lspf_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .cfg    (cfg),
  .res    (res)
);

### dv/least_squares_poly_fit_test.sv
// Testbench for least_squares_poly_fit: drives sample sets, predicts each fit
// with exact 192-bit arithmetic and checks every result item field by field.
// Depends on lspf_pkg, the lspf channel interfaces and the block itself.
`timescale 1ns / 1ps
module least_squares_poly_fit_test;

  localparam int unsigned RUN_LIMIT  = 10000000;
  localparam int unsigned SOLVE_WAIT = 4000;

  typedef struct packed {
    logic [31:0] y;
    logic        last;
  } smp_item_t;

  typedef struct packed {
    logic [63:0]                a;
    logic [63:0]                b;
    logic [63:0]                c;
    logic                       sing;
    logic [lspf_pkg::CNT_W-1:0] pts;
  } fit_t;

  logic clk_i;
  logic rst_ni;

  lspf_cfg_if cfg ();
  lspf_smp_if smp ();
  lspf_res_if res ();

  least_squares_poly_fit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg   (cfg),
    .smp   (smp),
    .res   (res)
  );

  smp_item_t   sample_q[$];
  fit_t        fit_q[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_req;
  int unsigned hold_left;
  bit          smp_taken;

  // predictor state
  logic [1:0]  deg;
  logic [10:0] n_pts;
  logic [63:0] s1, s2, s3, s4, t0, t1, t2;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [191:0] prod3(input logic [63:0] a, input logic [63:0] b,
                                         input logic [63:0] c);
    logic [191:0] wa, wb, wc;
    wa = {{128{a[63]}}, a};
    wb = {{128{b[63]}}, b};
    wc = {{128{c[63]}}, c};
    return wa * wb * wc;
  endfunction

  // num * 2^16 / den, truncated toward zero, saturated to 64 bits
  function automatic logic [63:0] q32_div(input logic [191:0] num, input logic [191:0] den);
    logic [191:0] ns, n, d, q, lim;
    logic         neg;
    neg = num[191] ^ den[191];
    ns  = num << 16;
    n   = ns[191] ? -ns : ns;
    d   = den[191] ? -den : den;
    q   = n / d;
    lim = neg ? (192'd1 << 63) : ((192'd1 << 63) - 192'd1);
    if (q > lim) q = lim;
    return neg ? -q[63:0] : q[63:0];
  endfunction

  function automatic void clear_sums();
    n_pts = '0;
    {s1, s2, s3, s4, t0, t1, t2} = '0;
  endfunction

  task automatic predict_fit(input logic [31:0] y_in, input logic last);
    logic [63:0]  y, x, x2, s0;
    logic [191:0] det, na, nb, nc;
    fit_t         f;
    y = {{32{y_in[31]}}, y_in};
    if (n_pts < lspf_pkg::MAX_POINTS) begin
      x  = 64'(n_pts) + 64'd1;
      x2 = x * x;
      s1 += x;
      s2 += x2;
      s3 += x2 * x;
      s4 += x2 * x2;
      t0 += y;
      t1 += x * y;
      t2 += x2 * y;
      n_pts++;
    end
    if (last) begin
      s0 = 64'(n_pts);
      if (deg[1]) begin
        det = prod3(s4, s2, s0) - prod3(s4, s1, s1) - prod3(s3, s3, s0)
            + prod3(s3, s1, s2) + prod3(s2, s3, s1) - prod3(s2, s2, s2);
        na  = prod3(t2, s2, s0) - prod3(t2, s1, s1) - prod3(s3, t1, s0)
            + prod3(s3, s1, t0) + prod3(s1, t1, s2) - prod3(t0, s2, s2);
        nb  = prod3(s4, t1, s0) - prod3(s4, s1, t0) - prod3(t2, s0, s3)
            + prod3(t2, s1, s2) + prod3(s2, s3, t0) - prod3(s2, t1, s2);
        nc  = prod3(s4, s2, t0) - prod3(s4, t1, s1) - prod3(s3, t0, s3)
            + prod3(s3, t1, s2) + prod3(t2, s3, s1) - prod3(t2, s2, s2);
      end else begin
        det = prod3(s2, s0, 64'd1) - prod3(s1, s1, 64'd1);
        na  = '0;
        nb  = prod3(t1, s0, 64'd1) - prod3(s1, t0, 64'd1);
        nc  = prod3(s2, t0, 64'd1) - prod3(s1, t1, 64'd1);
      end
      if (det == '0) begin
        f.a = '0; f.b = '0; f.c = '0; f.sing = 1'b1;
      end else begin
        f.a = q32_div(na, det);
        f.b = q32_div(nb, det);
        f.c = q32_div(nc, det);
        f.sing = 1'b0;
      end
      f.pts = n_pts;
      fit_q = {fit_q, f};
      clear_sums();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
  endtask

  // monitor: accepts on the rising edge
  always @(posedge clk_i) begin
    fit_t want;
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) deg = cfg.fit_degree;
      if (smp.valid && smp.ready) begin
        predict_fit(smp.sample, smp.last_sample);
        smp_taken = 1'b1;
      end
      if (res.valid && res.ready) begin
        if (fit_q.size() == 0) begin
          report_mismatch("result count", 64'd1, 64'd0);
        end else begin
          want = fit_q.pop_front();
          if (res.coef_square !== want.a) report_mismatch("coef_square", res.coef_square, want.a);
          if (res.coef_linear !== want.b) report_mismatch("coef_linear", res.coef_linear, want.b);
          if (res.coef_constant !== want.c)
            report_mismatch("coef_constant", res.coef_constant, want.c);
          if (res.singular !== want.sing) report_mismatch("singular", 64'(res.singular),
                                                          64'(want.sing));
          if (res.points_used !== want.pts) report_mismatch("points_used",
                                                            64'(res.points_used), 64'(want.pts));
        end
      end
    end
  end

  // sample driver
  always @(negedge clk_i) begin
    smp_item_t it;
    if (rst_ni && (!smp.valid || smp_taken)) begin
      smp_taken = 1'b0;
      if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        it = sample_q.pop_front();
        smp.sample      <= it.y;
        smp.last_sample <= it.last;
        smp.valid       <= 1'b1;
      end else begin
        smp.valid <= 1'b0;
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 20000;
    end
    if (hold_left != 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return 32'(signed'($urandom_range(200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_set(input int unsigned len);
    smp_item_t it;
    for (int unsigned i = 1; i <= len; i++) begin
      it.y    = pick_sample();
      it.last = (i == len);
      sample_q = {sample_q, it};
    end
  endtask

  task automatic add_fixed(input logic [31:0] y, input logic last);
    smp_item_t it;
    it.y    = y;
    it.last = last;
    sample_q = {sample_q, it};
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || smp.valid || fit_q.size() != 0) @(posedge clk_i);
    repeat (SOLVE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_degree(input logic [1:0] d);
    @(negedge clk_i);
    cfg.fit_degree <= d;
    cfg.valid      <= 1'b1;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_sets(input int unsigned n_items);
    int unsigned done;
    int unsigned len;
    done = 0;
    while (done < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
      add_set(len);
      done += len;
    end
  endtask

  initial begin
    errors = 0; cycles = 0; hold_req = 0; hold_left = 0; smp_taken = 0;
    tx_idle_pct = 22; rx_idle_pct = 71;
    deg = 2'd1;
    clear_sums();
    smp.valid = 1'b0; smp.sample = '0; smp.last_sample = 1'b0;
    cfg.valid = 1'b0; cfg.fit_degree = 2'd1;
    res.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // line fit from reset: single point is singular, then extremes
    add_fixed(32'h7FFF_FFFF, 1'b1);
    add_fixed(32'h7FFF_FFFF, 1'b0);
    add_fixed(32'h8000_0000, 1'b1);
    add_fixed(32'h8000_0000, 1'b0);
    add_fixed(32'h7FFF_FFFF, 1'b0);
    add_fixed(32'h0001_0000, 1'b1);
    add_fixed(32'hFFFF_FFFF, 1'b0);
    add_fixed(32'h0000_0000, 1'b1);
    drain();

    // quadratic: one and two points singular, then extremes, then y = x^2 exactly
    write_degree(2'd2);
    add_fixed(32'h8000_0000, 1'b1);
    add_fixed(32'h7FFF_FFFF, 1'b0);
    add_fixed(32'h8000_0000, 1'b1);
    add_fixed(32'h8000_0000, 1'b0);
    add_fixed(32'h7FFF_FFFF, 1'b0);
    add_fixed(32'h8000_0000, 1'b1);
    add_fixed(32'h0001_0000, 1'b0);
    add_fixed(32'h0004_0000, 1'b0);
    add_fixed(32'h0009_0000, 1'b1);
    drain();

    write_degree(2'd0);
    random_sets(100);
    drain();

    tx_idle_pct = 71; rx_idle_pct = 22;
    write_degree(2'd3);
    random_sets(100);
    drain();

    // no idling; receiver held off so the set queue fills and input stalls
    tx_idle_pct = 0; rx_idle_pct = 0;
    write_degree(2'd1);
    hold_req = 1'b1;
    random_sets(110);
    drain();

    write_degree(2'd2);
    random_sets(110);
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
